/* design/pfba_pkg.sv */
// Shared types and constants for the page frame bitmap allocator.
// No dependencies.
`timescale 1ns / 1ps

package pfba_pkg;

   localparam int PAGE_W = 20;
   localparam int CNT_W  = 8;
   localparam int DEF_MAX_BLOCKS      = 16;
   localparam int DEF_PAGES_PER_BLOCK = 128;

   localparam logic [2:0] OP_ADD        = 3'd0;
   localparam logic [2:0] OP_REMOVE     = 3'd1;
   localparam logic [2:0] OP_ALLOC_PAGE = 3'd2;
   localparam logic [2:0] OP_ALLOC_RUN  = 3'd3;
   localparam logic [2:0] OP_SET_FLAG   = 3'd4;
   localparam logic [2:0] OP_QUERY      = 3'd5;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam logic [1:0] FLAG_USED  = 2'd0;
   localparam logic [1:0] FLAG_DIRTY = 2'd1;
   localparam logic [1:0] FLAG_POUT  = 2'd2;

   typedef struct packed {
      logic [2:0]        operation;
      logic [PAGE_W-1:0] page;
      logic [CNT_W-1:0]  count;
      logic [4:0]        align_log2;
      logic [1:0]        flag_select;
      logic              flag_value;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [PAGE_W-1:0] result_page;
      logic              is_used;
      logic              is_dirty;
      logic              is_paged_out;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic add;
      logic eval;
      logic next_idx;
      logic next_off;
      logic rd_next;
      logic cp_wr;
      logic rm_done;
      logic load_out;
   } ctl_cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       hit;
      logic       run_last;
      logic       idx_end;
      logic       cp_last;
      logic       out_free;
   } dp_sts_type;

endpackage

/* design/pfba_datapath.sv */
// Datapath: block table memories, scan registers, bit search and result register.
// Depends on pfba_pkg.
`timescale 1ns / 1ps

module pfba_datapath #(
   parameter int MAX_BLOCKS      = pfba_pkg::DEF_MAX_BLOCKS,
   parameter int PAGES_PER_BLOCK = pfba_pkg::DEF_PAGES_PER_BLOCK
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pfba_pkg::req_type    req_data,
   output pfba_pkg::rsp_type    rsp_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  pfba_pkg::ctl_cmd_type cmd,
   output pfba_pkg::dp_sts_type  sts
);
   import pfba_pkg::*;

   localparam int IW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW  = $clog2(MAX_BLOCKS + 1);
   localparam int OW  = $clog2(PAGES_PER_BLOCK);
   localparam int PPB = PAGES_PER_BLOCK;

   // table memories, one row per block
   logic [PAGE_W-1:0] base_mem [MAX_BLOCKS];
   logic [CNT_W-1:0]  size_mem [MAX_BLOCKS];
   logic [PPB-1:0]    used_mem [MAX_BLOCKS];
   logic [PPB-1:0]    dirty_mem[MAX_BLOCKS];
   logic [PPB-1:0]    pout_mem [MAX_BLOCKS];

   req_type           item_ff;
   logic [CW-1:0]     cnt_ff, idx_ff;
   logic [OW-1:0]     off_ff;
   logic [PAGE_W-1:0] base_ff;
   logic [CNT_W-1:0]  size_ff;
   logic [PPB-1:0]    used_ff, dirty_ff, pout_ff;
   rsp_type           res_ff, rsp_ff;
   logic              rsp_valid_ff;

   logic [CW-1:0]     rd_addr, idx_inc;
   logic [PAGE_W-1:0] page_off, amask, run_start;
   logic [OW-1:0]     bit_idx, free_pos;
   logic              contains, free_hit, aligned, conflict, run_hit, hit, add_ok;
   logic [8:0]        run_end;
   logic [PPB-1:0]    runmask, nu, nd, np;
   logic              wr_en;
   logic [CW-1:0]     wa;
   logic [PAGE_W-1:0] wbase;
   logic [CNT_W-1:0]  wsize;
   logic [PPB-1:0]    wused, wdirty, wpout;

   assign idx_inc = CW'(idx_ff + CW'(1));
   assign rd_addr = cmd.rd_next ? idx_inc : idx_ff;

   always_ff @(posedge clock) begin
      base_ff  <= base_mem [rd_addr[IW-1:0]];
      size_ff  <= size_mem [rd_addr[IW-1:0]];
      used_ff  <= used_mem [rd_addr[IW-1:0]];
      dirty_ff <= dirty_mem[rd_addr[IW-1:0]];
      pout_ff  <= pout_mem [rd_addr[IW-1:0]];
      if (wr_en) begin
         base_mem [wa[IW-1:0]] <= wbase;
         size_mem [wa[IW-1:0]] <= wsize;
         used_mem [wa[IW-1:0]] <= wused;
         dirty_mem[wa[IW-1:0]] <= wdirty;
         pout_mem [wa[IW-1:0]] <= wpout;
      end
   end

   // containment, wrapping 20-bit offset
   assign page_off = item_ff.page - base_ff;
   assign contains = page_off < PAGE_W'(size_ff);
   assign bit_idx  = page_off[OW-1:0];

   // first free page below the block size
   always_comb begin
      free_hit = 1'b0;
      free_pos = '0;
      for (int j = PPB - 1; j >= 0; j--) begin
         if (!used_ff[j] && (9'(j) < 9'(size_ff))) begin
            free_hit = 1'b1;
            free_pos = OW'(j);
         end
      end
   end

   // aligned run candidate at off_ff
   assign run_end   = 9'(off_ff) + 9'(item_ff.count);
   assign amask     = (item_ff.align_log2 >= 5'd20) ? '1 :
                      PAGE_W'((21'd1 << item_ff.align_log2) - 21'd1);
   assign run_start = base_ff + PAGE_W'(off_ff);
   assign aligned   = (run_start & amask) == '0;

   always_comb begin
      for (int j = 0; j < PPB; j++) begin
         runmask[j] = (9'(j) >= 9'(off_ff)) && (9'(j) < run_end);
      end
   end

   assign conflict = |(used_ff & runmask);
   assign run_hit  = (9'(off_ff) < 9'(size_ff)) && (run_end <= 9'(size_ff)) &&
                     aligned && !conflict;

   always_comb begin
      case (item_ff.operation)
         OP_REMOVE:     hit = (base_ff == item_ff.page);
         OP_ALLOC_PAGE: hit = free_hit;
         OP_ALLOC_RUN:  hit = run_hit;
         OP_SET_FLAG:   hit = contains;
         OP_QUERY:      hit = contains;
         default:       hit = 1'b0;
      endcase
   end

   // flag write for set
   always_comb begin
      nu = used_ff;
      nd = dirty_ff;
      np = pout_ff;
      case (item_ff.flag_select)
         FLAG_USED:  nu[bit_idx] = item_ff.flag_value;
         FLAG_DIRTY: nd[bit_idx] = item_ff.flag_value;
         FLAG_POUT:  np[bit_idx] = item_ff.flag_value;
         default:    ;
      endcase
   end

   assign add_ok = (cnt_ff < CW'(MAX_BLOCKS)) && (item_ff.count <= CNT_W'(PPB));

   // single write port
   always_comb begin
      wr_en  = 1'b0;
      wa     = idx_ff;
      wbase  = base_ff;
      wsize  = size_ff;
      wused  = used_ff;
      wdirty = dirty_ff;
      wpout  = pout_ff;
      if (cmd.add) begin
         wr_en  = add_ok;
         wa     = cnt_ff;
         wbase  = item_ff.page;
         wsize  = item_ff.count;
         wused  = '0;
         wdirty = '0;
         wpout  = '0;
      end else if (cmd.cp_wr) begin
         wr_en = 1'b1;
      end else if (cmd.eval && hit) begin
         case (item_ff.operation)
            OP_ALLOC_PAGE: begin
               wr_en = 1'b1;
               wused = used_ff | (PPB'(1) << free_pos);
            end
            OP_ALLOC_RUN: begin
               wr_en = 1'b1;
               wused = used_ff | runmask;
            end
            OP_SET_FLAG: begin
               wr_en  = 1'b1;
               wused  = nu;
               wdirty = nd;
               wpout  = np;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         item_ff <= req_data;
      end
      if (cmd.start) begin
         res_ff <= '{status: ST_MISS, result_page: '0,
                     is_used: (req_data.operation == OP_QUERY),
                     is_dirty: 1'b0, is_paged_out: 1'b0};
      end else if (cmd.add) begin
         res_ff.status <= add_ok ? ST_OK : ST_FULL;
      end else if (cmd.rm_done) begin
         res_ff.status <= ST_OK;
      end else if (cmd.eval && hit) begin
         case (item_ff.operation)
            OP_ALLOC_PAGE: begin
               res_ff.status      <= ST_OK;
               res_ff.result_page <= base_ff + PAGE_W'(free_pos);
            end
            OP_ALLOC_RUN: begin
               res_ff.status      <= ST_OK;
               res_ff.result_page <= run_start;
            end
            OP_SET_FLAG: res_ff.status <= ST_OK;
            OP_QUERY: begin
               res_ff.status       <= ST_OK;
               res_ff.is_used      <= used_ff[bit_idx];
               res_ff.is_dirty     <= dirty_ff[bit_idx];
               res_ff.is_paged_out <= pout_ff[bit_idx];
            end
            default: ;
         endcase
      end
      if (cmd.start || cmd.next_idx) begin
         off_ff <= '0;
      end else if (cmd.next_off) begin
         off_ff <= OW'(off_ff + OW'(1));
      end
      if (cmd.start) begin
         idx_ff <= '0;
      end else if (cmd.next_idx) begin
         idx_ff <= idx_inc;
      end
      if (cmd.load_out) begin
         rsp_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.add && add_ok) begin
            cnt_ff <= CW'(cnt_ff + CW'(1));
         end else if (cmd.rm_done) begin
            cnt_ff <= CW'(cnt_ff - CW'(1));
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.op       = item_ff.operation;
   assign sts.hit      = hit;
   assign sts.run_last = ((9'(off_ff) + 9'd1) >= 9'(size_ff)) || (off_ff == OW'(PPB - 1));
   assign sts.idx_end  = idx_ff >= cnt_ff;
   assign sts.cp_last  = ({1'b0, idx_ff} + (CW + 1)'(1)) >= {1'b0, cnt_ff};
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

/* design/pfba_ctrl.sv */
// Controller: sequences dispatch, table scan, entry shift on remove and result hand-off.
// Depends on pfba_pkg.
`timescale 1ns / 1ps

module pfba_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  pfba_pkg::dp_sts_type  sts,
   output pfba_pkg::ctl_cmd_type cmd
);
   import pfba_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DISP = 3'd1;
   localparam logic [2:0] S_RD   = 3'd2;
   localparam logic [2:0] S_EV   = 3'd3;
   localparam logic [2:0] S_CPRD = 3'd4;
   localparam logic [2:0] S_CPWR = 3'd5;
   localparam logic [2:0] S_FIN  = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_DISP;
            end
         end
         S_DISP: begin
            if (sts.op == OP_ADD) begin
               cmd.add  = 1'b1;
               state_in = S_FIN;
            end else if (sts.op inside {[OP_REMOVE:OP_QUERY]}) begin
               state_in = S_RD;
            end else begin
               state_in = S_FIN;
            end
         end
         S_RD: state_in = sts.idx_end ? S_FIN : S_EV;
         S_EV: begin
            cmd.eval = 1'b1;
            case (sts.op)
               OP_REMOVE: begin
                  if (sts.hit) begin
                     state_in = S_CPRD;
                  end else begin
                     cmd.next_idx = 1'b1;
                     state_in     = S_RD;
                  end
               end
               OP_ALLOC_RUN: begin
                  if (sts.hit) begin
                     state_in = S_FIN;
                  end else if (sts.run_last) begin
                     cmd.next_idx = 1'b1;
                     state_in     = S_RD;
                  end else begin
                     cmd.next_off = 1'b1;
                  end
               end
               OP_SET_FLAG: begin
                  cmd.next_idx = 1'b1;
                  state_in     = S_RD;
               end
               default: begin
                  if (sts.hit) begin
                     state_in = S_FIN;
                  end else begin
                     cmd.next_idx = 1'b1;
                     state_in     = S_RD;
                  end
               end
            endcase
         end
         S_CPRD: begin
            if (sts.cp_last) begin
               cmd.rm_done = 1'b1;
               state_in    = S_FIN;
            end else begin
               cmd.rd_next = 1'b1;
               state_in    = S_CPWR;
            end
         end
         S_CPWR: begin
            cmd.cp_wr    = 1'b1;
            cmd.next_idx = 1'b1;
            state_in     = S_CPRD;
         end
         S_FIN: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

/* design/page_frame_bitmap_allocator.sv */
// Top level of the page frame bitmap allocator: controller plus datapath.
// Depends on pfba_pkg, pfba_ctrl, pfba_datapath.
`timescale 1ns / 1ps
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+---------------------------
//  request | req_valid | req_stall | req_data (pfba_pkg::req_type)
//  result  | rsp_valid | rsp_stall | rsp_data (pfba_pkg::rsp_type)
//
// One item at a time. Add is written in the dispatch state, then handed off; other operations walk
// the block table with one registered memory read and one evaluate per entry.
// Alloc run evaluates one candidate start per cycle, up to the block size per block.
// Remove shifts each later entry down with a read and a write. Reset clears only
// the block count and control; table rows are written by add before any read.
// The result register frees the scan: a new request is taken while a result waits.

module page_frame_bitmap_allocator #(
   parameter int MAX_BLOCKS      = pfba_pkg::DEF_MAX_BLOCKS,
   parameter int PAGES_PER_BLOCK = pfba_pkg::DEF_PAGES_PER_BLOCK
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pfba_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pfba_pkg::rsp_type rsp_data
);
   import pfba_pkg::*;

   ctl_cmd_type cmd;   // controller to datapath
   dp_sts_type  sts;   // datapath to controller

   pfba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   pfba_datapath #(
      .MAX_BLOCKS      (MAX_BLOCKS),
      .PAGES_PER_BLOCK (PAGES_PER_BLOCK)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // a transfer always starts work, so the request side closes next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request side not closed after transfer");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status != 2'd3)
      else $error("undefined status code");

   a_fail_page_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.result_page == '0)
      else $error("failed result carries a page number");

endmodule

/* test/pfba_checker.sv */
// Checker for the page frame bitmap allocator: watches both channels,
// predicts each result and compares it. Depends on pfba_pkg.
`timescale 1ns / 1ps

module pfba_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  pfba_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  pfba_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending
);
   import pfba_pkg::*;

   localparam int NBLK = DEF_MAX_BLOCKS;
   localparam int NPG  = DEF_PAGES_PER_BLOCK;

   int                tbl_count;
   logic [PAGE_W-1:0] tbl_base  [NBLK];
   int                tbl_pages [NBLK];
   logic [NPG-1:0]    used_bits [NBLK];
   logic [NPG-1:0]    dirty_bits[NBLK];
   logic [NPG-1:0]    pout_bits [NBLK];
   rsp_type           rsp_expected[$];

   assign pending = rsp_expected.size();

   // page offset in block k, -1 when outside (20-bit wrap)
   function automatic int page_offset(int k, logic [PAGE_W-1:0] pg);
      logic [PAGE_W-1:0] off;
      off = pg - tbl_base[k];
      return (int'(off) < tbl_pages[k]) ? int'(off) : -1;
   endfunction

   function automatic rsp_type allocator_step(req_type r);
      rsp_type           o;
      logic [PAGE_W-1:0] start, amask;
      logic              ok, done;
      int                off;
      o = '0;
      o.status = ST_MISS;
      done = 0;
      case (r.operation)
         OP_ADD: begin
            if (tbl_count >= NBLK || r.count > NPG) o.status = ST_FULL;
            else begin
               tbl_base[tbl_count]   = r.page;
               tbl_pages[tbl_count]  = r.count;
               used_bits[tbl_count]  = '0;
               dirty_bits[tbl_count] = '0;
               pout_bits[tbl_count]  = '0;
               tbl_count++;
               o.status = ST_OK;
            end
         end
         OP_REMOVE: begin
            for (int i = 0; i < tbl_count && !done; i++)
               if (tbl_base[i] == r.page) begin
                  for (int a = i; a + 1 < tbl_count; a++) begin
                     tbl_base[a]   = tbl_base[a+1];
                     tbl_pages[a]  = tbl_pages[a+1];
                     used_bits[a]  = used_bits[a+1];
                     dirty_bits[a] = dirty_bits[a+1];
                     pout_bits[a]  = pout_bits[a+1];
                  end
                  tbl_count--;
                  o.status = ST_OK;
                  done = 1;
               end
         end
         OP_ALLOC_PAGE: begin
            for (int i = 0; i < tbl_count && !done; i++)
               for (int a = 0; a < tbl_pages[i] && !done; a++)
                  if (!used_bits[i][a]) begin
                     used_bits[i][a] = 1'b1;
                     o.result_page = tbl_base[i] + a[PAGE_W-1:0];
                     o.status = ST_OK;
                     done = 1;
                  end
         end
         OP_ALLOC_RUN: begin
            // align of 20 or more leaves only page 0 aligned
            amask = (r.align_log2 >= 20) ? '1 : ((20'd1 << r.align_log2) - 20'd1);
            for (int i = 0; i < tbl_count && !done; i++)
               for (int a = 0; a < tbl_pages[i] && !done; a++) begin
                  start = tbl_base[i] + a[PAGE_W-1:0];
                  if ((start & amask) == 0) begin
                     if (a + int'(r.count) > tbl_pages[i]) break;
                     ok = 1;
                     for (int b = 0; b < r.count; b++)
                        if (used_bits[i][a+b]) ok = 0;
                     if (ok) begin
                        for (int b = 0; b < r.count; b++) used_bits[i][a+b] = 1'b1;
                        o.result_page = start;
                        o.status = ST_OK;
                        done = 1;
                     end
                  end
               end
         end
         OP_SET_FLAG: begin
            for (int i = 0; i < tbl_count; i++) begin
               off = page_offset(i, r.page);
               if (off >= 0) begin
                  o.status = ST_OK;
                  case (r.flag_select)
                     FLAG_USED:  used_bits[i][off]  = r.flag_value;
                     FLAG_DIRTY: dirty_bits[i][off] = r.flag_value;
                     FLAG_POUT:  pout_bits[i][off]  = r.flag_value;
                     default: ;
                  endcase
               end
            end
         end
         OP_QUERY: begin
            o.is_used = 1'b1;
            for (int i = 0; i < tbl_count && !done; i++) begin
               off = page_offset(i, r.page);
               if (off >= 0) begin
                  o.is_used      = used_bits[i][off];
                  o.is_dirty     = dirty_bits[i][off];
                  o.is_paged_out = pout_bits[i][off];
                  o.status = ST_OK;
                  done = 1;
               end
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         tbl_count = 0;
         fail_count <= 0;
         rsp_expected.delete();
      end else begin
         if (req_valid && !req_stall) rsp_expected.push_back(allocator_step(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (rsp_expected.size() == 0) begin
               if (fail_count < 10) $display("unexpected result %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = rsp_expected.pop_front();
               if (want !== rsp_data) begin
                  if (fail_count < 10)
                     $display("mismatch: expected %p actual %p", want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

/* test/page_frame_bitmap_allocator_tb.sv */
// Testbench top for the page frame bitmap allocator: stimulus, stalls, verdict.
// Depends on pfba_pkg, page_frame_bitmap_allocator, pfba_checker.
`timescale 1ns / 1ps

module page_frame_bitmap_allocator_tb;
   import pfba_pkg::*;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;
   int      fail_count, pending;
   logic    stall_on = 1;   // receiver stalls enabled

   // pages in recently added blocks, so set/query/remove mostly hit
   logic [PAGE_W-1:0] base_pool[$];

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   page_frame_bitmap_allocator dut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );

   pfba_checker chk (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .fail_count, .pending
   );

   // receiver: random stalls while stall_on is set, none otherwise
   always @(posedge clock) begin
      int phase;
      phase = $urandom_range(0, 99);
      if (!stall_on) rsp_stall <= 0;
      else if (phase < 30) rsp_stall <= ($urandom_range(0, 3) == 0);
      else if (phase < 40) rsp_stall <= 1;
      else rsp_stall <= 0;
   end

   // hand one transfer to the block; holds payload until accepted
   task automatic send_req(req_type r);
      req_valid <= 1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic idle_gap();
      int n;
      req_valid <= 0;
      n = $urandom_range(1, 6);
      repeat (n) @(posedge clock);
   endtask

   function automatic req_type make_req(logic [2:0] op, logic [PAGE_W-1:0] pg,
                                        logic [7:0] cnt, logic [4:0] al,
                                        logic [1:0] fs, logic fv);
      req_type r;
      r.operation = op; r.page = pg; r.count = cnt;
      r.align_log2 = al; r.flag_select = fs; r.flag_value = fv;
      return r;
   endfunction

   function automatic logic [PAGE_W-1:0] near_page();
      if (base_pool.size() == 0 || $urandom_range(0, 9) == 0) return PAGE_W'($urandom());
      return base_pool[$urandom_range(0, base_pool.size() - 1)]
             + PAGE_W'($urandom_range(0, 130));
   endfunction

   function automatic req_type random_req();
      req_type           r;
      logic [PAGE_W-1:0] pg;
      logic [63:0]       noise;
      int                sel;
      noise = {$urandom(), $urandom()};
      r = noise[$bits(req_type)-1:0];    // noise in every field first
      sel = $urandom_range(0, 99);
      if (sel < 3) return r;   // raw noise, includes ops 6 and 7
      pg = near_page();
      if (sel < 20) begin
         pg = ($urandom_range(0, 3) == 0) ? PAGE_W'($urandom())
                                          : {8'($urandom_range(0, 255)), 12'h000};
         r = make_req(OP_ADD, pg, 8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                                : $urandom_range(0, 128)),
                      5'($urandom()), 2'($urandom()), 1'($urandom()));
      end else if (sel < 28)
         r = make_req(OP_REMOVE, base_pool.size() && $urandom_range(0, 3)
                      ? base_pool[$urandom_range(0, base_pool.size() - 1)] : pg,
                      8'($urandom()), 5'($urandom()), 2'($urandom()), 1'($urandom()));
      else if (sel < 45)
         r = make_req(OP_ALLOC_PAGE, PAGE_W'($urandom()), 8'($urandom()), 5'($urandom()),
                      2'($urandom()), 1'($urandom()));
      else if (sel < 60)
         r = make_req(OP_ALLOC_RUN, PAGE_W'($urandom()), 8'($urandom_range(0, 40)),
                      5'($urandom_range(0, 7) == 0 ? $urandom() : $urandom_range(0, 6)),
                      2'($urandom()), 1'($urandom()));
      else if (sel < 80)
         r = make_req(OP_SET_FLAG, pg, 8'($urandom()), 5'($urandom()),
                      2'($urandom_range(0, 3)), 1'($urandom()));
      else
         r = make_req(OP_QUERY, pg, 8'($urandom()), 5'($urandom()), 2'($urandom()),
                      1'($urandom()));
      if (r.operation == OP_ADD && base_pool.size() < 24) base_pool.push_back(r.page);
      return r;
   endfunction

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty table, extremes, refusals, overlap, wrap, odd ops
      send_req(make_req(OP_QUERY,      20'hFFFFF, 0, 0, 0, 0));
      send_req(make_req(OP_ALLOC_PAGE, 0, 0, 0, 0, 0));
      send_req(make_req(OP_REMOVE,     0, 0, 0, 0, 0));
      send_req(make_req(OP_ADD,        20'h100, 129, 0, 0, 0));    // size too large
      send_req(make_req(OP_ADD,        20'hFFFC0, 128, 0, 0, 0));  // wraps past top
      send_req(make_req(OP_ADD,        20'h00040, 0, 0, 0, 0));    // empty block
      send_req(make_req(OP_ADD,        20'hFFFE0, 64, 0, 0, 0));   // overlaps first
      send_req(make_req(OP_ALLOC_PAGE, 0, 0, 0, 0, 0));
      send_req(make_req(OP_ALLOC_RUN,  0, 0, 0, 0, 0));            // zero length
      send_req(make_req(OP_ALLOC_RUN,  0, 8, 3, 0, 0));
      send_req(make_req(OP_ALLOC_RUN,  0, 200, 0, 0, 0));          // longer than any block
      send_req(make_req(OP_ALLOC_RUN,  0, 1, 20, 0, 0));           // only page 0
      send_req(make_req(OP_ALLOC_RUN,  0, 1, 31, 0, 0));
      send_req(make_req(OP_SET_FLAG,   20'hFFFF0, 0, 0, FLAG_DIRTY, 1));
      send_req(make_req(OP_SET_FLAG,   20'h00010, 0, 0, FLAG_POUT, 1));
      send_req(make_req(OP_SET_FLAG,   20'h00011, 0, 0, FLAG_USED, 1));
      send_req(make_req(OP_SET_FLAG,   20'h00012, 0, 0, 2'd3, 1));
      send_req(make_req(OP_SET_FLAG,   20'h50000, 0, 0, FLAG_USED, 1));
      send_req(make_req(OP_QUERY,      20'hFFFF0, 0, 0, 0, 0));
      send_req(make_req(OP_QUERY,      20'h00010, 0, 0, 0, 0));
      send_req(make_req(OP_QUERY,      20'h00040, 0, 0, 0, 0));    // containment edge
      send_req(make_req(3'd6,          20'hFFFFF, 8'hFF, 5'h1F, 2'd3, 1));
      send_req(make_req(3'd7,          0, 0, 0, 0, 0));
      send_req(make_req(OP_REMOVE,     20'hFFFC0, 0, 0, 0, 0));
      for (int i = 0; i < 16; i++)                                 // fills, then refuses
         send_req(make_req(OP_ADD, 20'h1000 * i, 128, 0, 0, 0));
      req_valid <= 0;

      // random: bursts with gaps, one stretch without stalls
      for (int n = 0; n < 700; ) begin
         int burst;
         burst = $urandom_range(1, 12);
         stall_on <= !(n >= 300 && n < 400);
         repeat (burst) begin
            send_req(random_req());
            n++;
         end
         if ($urandom_range(0, 3) != 0) idle_gap();
         if (base_pool.size() > 20) base_pool.delete(0);
      end
      req_valid <= 0;
      stall_on  <= 1;

      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   // worst items walk 16 blocks x 128 starts x stalls; generous margin
   initial begin
      #100_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
